// ===== rtl/hri_pkg.sv =====
`timescale 1ns / 1ps
// hri_pkg: shared types, constants and helpers for the haptic rotation integrator.
// No dependencies.

package hri_pkg;

  localparam int CFG_FRAC = 16;

  localparam logic [1:0] CFG_INV_INERTIA   = 2'd0;
  localparam logic [1:0] CFG_VEL_CAP       = 2'd1;
  localparam logic [1:0] CFG_DAMPING       = 2'd2;
  localparam logic [1:0] CFG_MIN_ROT_SPEED = 2'd3;

  localparam logic [31:0] RST_INV_INERTIA   = 32'd163840;
  localparam logic [31:0] RST_VEL_CAP       = 32'd655360;
  localparam logic [16:0] RST_DAMPING       = 17'd6554;
  localparam logic [15:0] RST_MIN_ROT_SPEED = 16'd1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TORQ, ST_ACC, ST_INT, ST_SQ1, ST_RT1, ST_CAPM, ST_CAPD,
    ST_DTM, ST_DAMP, ST_SQ2, ST_RT2, ST_ANG, ST_AXD, ST_FIN
  } state_t;

  typedef enum logic {DS_DIV, DS_SQRT} ds_op_t;

  typedef struct packed {
    logic               go;
    logic [2:0]         tag;
    logic signed [32:0] a;
    logic signed [32:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               vld;
    logic [2:0]         tag;
    logic signed [65:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    ds_op_t      op;
    logic [32:0] rem0;
    logic [63:0] bits;
    logic [5:0]  cnt;
    logic [31:0] den;
  } ds_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] res;
  } ds_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
    logic signed [31:0] r;
    if (x > 72'sh0_0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -72'sh0_0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    logic [31:0] r;
    r = x[31] ? 32'(-x) : 32'(x);
    return r;
  endfunction

endpackage

// ===== rtl/hri_mul.sv =====
`timescale 1ns / 1ps
// hri_mul: shared 33x33 signed multiplier with registered product and tag.
// Depends on hri_pkg.

module hri_mul (
  input  logic              clk,
  input  logic              rst,
  input  hri_pkg::mul_req_t req,
  output hri_pkg::mul_rsp_t rsp
);
  import hri_pkg::*;

  logic signed [65:0] p;
  logic [2:0]         tag;
  logic               vld;

  always_ff @(posedge clk) begin
    if (req.go) begin
      p   <= req.a * req.b;
      tag <= req.tag;
    end
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= req.go;
    end
  end

  assign rsp = '{vld: vld, tag: tag, p: p};

endmodule

// ===== rtl/hri_dsu.sv =====
`timescale 1ns / 1ps
// hri_dsu: shared restoring divide / integer square root, one result bit a cycle.
// Depends on hri_pkg.

module hri_dsu (
  input  logic             clk,
  input  logic             rst,
  input  hri_pkg::ds_req_t req,
  output hri_pkg::ds_rsp_t rsp
);
  import hri_pkg::*;

  logic [34:0] rem;
  logic [63:0] bits;
  logic [31:0] res;
  logic [31:0] den;
  logic [5:0]  cnt;
  ds_op_t      op;
  logic        busy;
  logic        done;

  logic [34:0] r2;
  logic [34:0] sub_b;
  logic [35:0] diff;
  logic        ge;

  always_comb begin
    if (op == DS_SQRT) begin
      r2    = {rem[32:0], bits[63:62]};
      sub_b = {1'b0, res, 2'b01};
    end else begin
      r2    = {rem[33:0], bits[63]};
      sub_b = {3'b000, den};
    end
    diff = {1'b0, r2} - {1'b0, sub_b};
    ge   = !diff[35];
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= {2'b00, req.rem0};
      bits <= req.bits;
      res  <= '0;
      den  <= req.den;
      cnt  <= req.cnt;
      op   <= req.op;
    end else if (busy) begin
      rem  <= ge ? diff[34:0] : r2;
      res  <= {res[30:0], ge};
      bits <= (op == DS_SQRT) ? {bits[61:0], 2'b00} : {bits[62:0], 1'b0};
      cnt  <= cnt - 6'd1;
    end
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 6'd1);
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == 6'd1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign rsp = '{busy: busy, done: done, res: res};

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("dsu started while busy");
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (busy && cnt == 6'd1 && !req.start) |=> (done && !busy))
    else $error("dsu done missing");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("dsu done while busy");

endmodule

// ===== rtl/haptic_rotation_integrator_top.sv =====
`timescale 1ns / 1ps
// haptic_rotation_integrator_top: sequencer and datapath of one Euler rotation step.
// Depends on hri_pkg, hri_mul, hri_dsu.
//
//  channel | signals                               | beat when
//  --------+---------------------------------------+--------------------------
//  in      | in_valid/in_ready, tool, centre, force | in_valid & in_ready
//  out     | out_valid/out_ready, axis, angle, vel  | out_valid & out_ready
//  cfg     | cfg_we, cfg_idx, cfg_wdata             | cfg_we
//
//  Each beat runs its steps through the shared divide / square-root unit (one
//  bit a cycle) and the single shared multiplier; the rotation steps and the
//  speed-cap steps run only when they apply.
//  in_ready is high only while idle; a finished result waits in the output
//  registers while the next beat is taken. Reset clears velocity and out_valid and loads the config defaults.

module haptic_rotation_integrator_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] tool_x,
  input  logic signed [31:0] tool_y,
  input  logic signed [31:0] tool_z,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic signed [31:0] force_x,
  input  logic signed [31:0] force_y,
  input  logic signed [31:0] force_z,
  input  logic [16:0]        time_step,
  input  logic               user_switch,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [17:0] axis_x,
  output logic signed [17:0] axis_y,
  output logic signed [17:0] axis_z,
  output logic [30:0]        angle,
  output logic               rotate_valid,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic signed [31:0] vel_z,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [31:0]        cfg_wdata
);
  import hri_pkg::*;

  localparam int CAP_UP = (FRAC_BITS > CFG_FRAC) ? FRAC_BITS - CFG_FRAC : 0;
  localparam int CAP_DN = (FRAC_BITS < CFG_FRAC) ? CFG_FRAC - FRAC_BITS : 0;
  localparam int CW     = 32 + ((FRAC_BITS > CFG_FRAC) ? FRAC_BITS : CFG_FRAC);

  logic [31:0] inv_inertia;
  logic [31:0] vel_cap;
  logic [16:0] damping;
  logic [15:0] min_rot_speed;

  state_t state;
  state_t state_next;
  logic [2:0] k;
  logic [2:0] k_lim;
  logic [1:0] j;
  logic       restart;

  logic signed [31:0] v [3];
  logic signed [31:0] n [3];
  logic signed [31:0] t [3];
  logic signed [31:0] w [3];
  logic signed [17:0] ax [3];
  logic [16:0]        ts;
  logic               sw;
  logic signed [65:0] hold;
  logic [63:0]        sumsq;
  logic [63:0]        num;
  logic [31:0]        speed;
  logic [16:0]        factor;
  logic [30:0]        ang;
  logic               rot;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  ds_req_t  dreq;
  ds_rsp_t  drsp;

  logic signed [65:0] p_shf;
  logic signed [65:0] p_sh16;
  logic [31:0]        max_sh;
  logic [31:0]        mag_j;
  logic [63:0]        cap_prod;
  logic [32:0]        ang_raw;
  logic [17:0]        dt;
  logic               cap_above;
  logic               rot_now;
  logic [31:0]        q_s;
  logic [17:0]        q_a;

  hri_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));
  hri_dsu u_dsu (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    p_shf     = mrsp.p >>> FRAC_BITS;
    p_sh16    = mrsp.p >>> CFG_FRAC;
    max_sh    = vel_cap >> CAP_DN;
    mag_j     = mag32(w[j]);
    cap_prod  = mrsp.p[63:0] << CAP_UP;
    ang_raw   = mrsp.p[48:16];
    dt        = mrsp.p[33:16];
    cap_above = (CW'(drsp.res) << CFG_FRAC) > (CW'(vel_cap) << FRAC_BITS);
    rot_now   = ((CW'(drsp.res) << CFG_FRAC) > (CW'(min_rot_speed) << FRAC_BITS))
                && (drsp.res != 32'd0);
    q_s       = drsp.res;
    q_a       = drsp.res[17:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_TORQ;
      ST_TORQ: if (k == 3'd6) state_next = ST_ACC;
      ST_ACC:  if (k == 3'd3) state_next = ST_INT;
      ST_INT:  if (k == 3'd3) state_next = ST_SQ1;
      ST_SQ1:  if (k == 3'd3) state_next = ST_RT1;
      ST_RT1:  if (k == 3'd1 && drsp.done) state_next = cap_above ? ST_CAPM : ST_DTM;
      ST_CAPM: if (k == 3'd1) state_next = ST_CAPD;
      ST_CAPD: if (k == 3'd1 && drsp.done) state_next = (j == 2'd2) ? ST_DTM : ST_CAPM;
      ST_DTM:  if (k == 3'd1) state_next = ST_DAMP;
      ST_DAMP: if (k == 3'd3) state_next = ST_SQ2;
      ST_SQ2:  if (k == 3'd3) state_next = ST_RT2;
      ST_RT2:  if (k == 3'd1 && drsp.done) state_next = rot_now ? ST_ANG : ST_FIN;
      ST_ANG:  if (k == 3'd1) state_next = ST_AXD;
      ST_AXD:  if (k == 3'd1 && drsp.done && j == 2'd2) state_next = ST_FIN;
      ST_FIN:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    mreq  = '0;
    dreq  = '0;
    k_lim = 3'd0;
    mreq.tag = k;
    case (state)
      ST_TORQ: begin
        k_lim = 3'd6;
        case (k)
          3'd0:    begin mreq.a = 33'(v[1]); mreq.b = 33'(n[2]); end
          3'd1:    begin mreq.a = 33'(v[2]); mreq.b = 33'(n[1]); end
          3'd2:    begin mreq.a = 33'(v[2]); mreq.b = 33'(n[0]); end
          3'd3:    begin mreq.a = 33'(v[0]); mreq.b = 33'(n[2]); end
          3'd4:    begin mreq.a = 33'(v[0]); mreq.b = 33'(n[1]); end
          default: begin mreq.a = 33'(v[1]); mreq.b = 33'(n[0]); end
        endcase
      end
      ST_ACC: begin
        k_lim  = 3'd3;
        mreq.a = 33'(t[k[1:0]]);
        mreq.b = {1'b0, inv_inertia};
      end
      ST_INT: begin
        k_lim  = 3'd3;
        mreq.a = 33'(t[k[1:0]]);
        mreq.b = {16'd0, ts};
      end
      ST_SQ1, ST_SQ2: begin
        k_lim  = 3'd3;
        mreq.a = 33'(w[k[1:0]]);
        mreq.b = 33'(w[k[1:0]]);
      end
      ST_DAMP: begin
        k_lim  = 3'd3;
        mreq.a = 33'(w[k[1:0]]);
        mreq.b = {16'd0, factor};
      end
      ST_CAPM: begin
        k_lim  = 3'd1;
        mreq.a = {1'b0, mag_j};
        mreq.b = {1'b0, max_sh};
      end
      ST_DTM: begin
        k_lim  = 3'd1;
        mreq.a = {16'd0, damping};
        mreq.b = {16'd0, ts};
      end
      ST_ANG: begin
        k_lim  = 3'd1;
        mreq.a = {1'b0, speed};
        mreq.b = {16'd0, ts};
      end
      ST_RT1, ST_RT2: begin
        k_lim     = 3'd1;
        dreq.op   = DS_SQRT;
        dreq.bits = sumsq;
        dreq.cnt  = 6'd32;
      end
      ST_CAPD: begin
        k_lim     = 3'd1;
        dreq.op   = DS_DIV;
        dreq.rem0 = {1'b0, num[63:32]};
        dreq.bits = {num[31:0], 32'd0};
        dreq.cnt  = 6'd32;
        dreq.den  = speed;
      end
      ST_AXD: begin
        k_lim     = 3'd1;
        dreq.op   = DS_DIV;
        dreq.rem0 = {2'b00, mag_j[31:1]};
        dreq.bits = {mag_j[0], 63'd0};
        dreq.cnt  = 6'd17;
        dreq.den  = speed;
      end
      default: k_lim = 3'd0;
    endcase
    case (state)
      ST_TORQ, ST_ACC, ST_INT, ST_SQ1, ST_SQ2, ST_DAMP, ST_CAPM, ST_DTM, ST_ANG:
        mreq.go = (k < k_lim);
      default: mreq.go = 1'b0;
    endcase
    case (state)
      ST_RT1, ST_RT2, ST_CAPD, ST_AXD: dreq.start = (k == 3'd0);
      default:                         dreq.start = 1'b0;
    endcase
    restart = (state_next != state) || (state == ST_AXD && k == 3'd1 && drsp.done);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      k             <= 3'd0;
      j             <= 2'd0;
      out_valid     <= 1'b0;
      inv_inertia   <= RST_INV_INERTIA;
      vel_cap       <= RST_VEL_CAP;
      damping       <= RST_DAMPING;
      min_rot_speed <= RST_MIN_ROT_SPEED;
      for (int i = 0; i < 3; i++) begin
        w[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (restart) begin
        k <= 3'd0;
      end else if (k != k_lim) begin
        k <= k + 3'd1;
      end

      if (cfg_we) begin
        case (cfg_idx)
          CFG_INV_INERTIA:   inv_inertia   <= cfg_wdata;
          CFG_VEL_CAP:       vel_cap       <= cfg_wdata;
          CFG_DAMPING:       damping       <= cfg_wdata[16:0];
          CFG_MIN_ROT_SPEED: min_rot_speed <= cfg_wdata[15:0];
          default:           inv_inertia   <= inv_inertia;
        endcase
      end

      if (state == ST_FIN) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            v[0] <= sat32(72'(tool_x) - 72'(center_x));
            v[1] <= sat32(72'(tool_y) - 72'(center_y));
            v[2] <= sat32(72'(tool_z) - 72'(center_z));
            n[0] <= sat32(-72'(force_x));
            n[1] <= sat32(-72'(force_y));
            n[2] <= sat32(-72'(force_z));
            ts   <= time_step;
            sw   <= user_switch;
          end
        end
        ST_TORQ: begin
          if (mrsp.vld) begin
            if (!mrsp.tag[0]) begin
              hold <= p_shf;
            end else begin
              t[mrsp.tag[2:1]] <= sat32(72'(hold) - 72'(p_shf));
            end
          end
        end
        ST_ACC: if (mrsp.vld) t[mrsp.tag[1:0]] <= sat32(72'(p_sh16));
        ST_INT: begin
          if (mrsp.vld) begin
            w[mrsp.tag[1:0]] <= sat32(72'(w[mrsp.tag[1:0]]) + 72'(p_sh16));
          end
        end
        ST_SQ1, ST_SQ2: begin
          if (mrsp.vld) begin
            sumsq <= (mrsp.tag == 3'd0) ? mrsp.p[63:0] : sumsq + mrsp.p[63:0];
          end
        end
        ST_RT1: begin
          if (k == 3'd1 && drsp.done) begin
            speed <= drsp.res;
            j     <= 2'd0;
          end
        end
        ST_CAPM: if (mrsp.vld) num <= cap_prod;
        ST_CAPD: begin
          if (k == 3'd1 && drsp.done) begin
            w[j] <= w[j][31] ? -$signed(q_s) : $signed(q_s);
            j    <= j + 2'd1;
          end
        end
        ST_DTM: begin
          if (mrsp.vld) begin
            factor <= (dt[17:16] != 2'd0) ? 17'd0 : 17'h10000 - {1'b0, dt[15:0]};
          end
        end
        ST_DAMP: begin
          if (mrsp.vld) begin
            w[mrsp.tag[1:0]] <= sw ? 32'sd0 : p_sh16[31:0];
          end
        end
        ST_RT2: begin
          if (k == 3'd1 && drsp.done) begin
            speed <= drsp.res;
            rot   <= rot_now;
            j     <= 2'd0;
          end
        end
        ST_ANG: begin
          if (mrsp.vld) begin
            ang <= (ang_raw[32:31] != 2'd0) ? 31'h7FFF_FFFF : ang_raw[30:0];
          end
        end
        ST_AXD: begin
          if (k == 3'd1 && drsp.done) begin
            ax[j] <= w[j][31] ? -$signed(q_a) : $signed(q_a);
            j     <= j + 2'd1;
          end
        end
        ST_FIN: begin
          if (!out_valid || out_ready) begin
            rotate_valid <= rot;
            axis_x       <= rot ? ax[0] : 18'sd0;
            axis_y       <= rot ? ax[1] : 18'sd0;
            axis_z       <= rot ? ax[2] : 18'sd0;
            angle        <= rot ? ang : 31'd0;
            vel_x        <= w[0];
            vel_y        <= w[1];
            vel_z        <= w[2];
          end
        end
        default: hold <= hold;
      endcase
    end
  end

  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second beat taken while busy");
  a_norot_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rotate_valid) |->
      (angle == 31'd0 && axis_x == 18'sd0 && axis_y == 18'sd0 && axis_z == 18'sd0))
    else $error("axis or angle set without rotation");
  a_axis_unit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (axis_x <= 18'sd65536 && axis_x >= -18'sd65536 &&
                   axis_y <= 18'sd65536 && axis_y >= -18'sd65536 &&
                   axis_z <= 18'sd65536 && axis_z >= -18'sd65536))
    else $error("axis component out of unit range");
  a_switch_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && sw) |-> (w[0] == 32'sd0 && w[1] == 32'sd0 && w[2] == 32'sd0))
    else $error("velocity not cleared by switch");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for haptic_rotation_integrator_top; a directed table, then random ticks.
// Depends on hri_pkg and the RTL of the block; results are checked against a local predictor.

module tb;
  import hri_pkg::*;

  localparam int FB = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] tool_x = '0, tool_y = '0, tool_z = '0;
  logic signed [31:0] center_x = '0, center_y = '0, center_z = '0;
  logic signed [31:0] force_x = '0, force_y = '0, force_z = '0;
  logic [16:0] time_step = '0;
  logic user_switch = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [17:0] axis_x, axis_y, axis_z;
  logic [30:0] angle;
  logic rotate_valid;
  logic signed [31:0] vel_x, vel_y, vel_z;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [31:0] cfg_wdata = '0;

  haptic_rotation_integrator_top #(.FRAC_BITS(FB)) u_top (.*);

  always #1 clk = ~clk;

  typedef struct {
    logic signed [31:0] tool[3];
    logic signed [31:0] ctr[3];
    logic signed [31:0] frc[3];
    logic [16:0] ts;
    logic sw;
  } tick_t;

  typedef struct {
    logic signed [17:0] ax[3];
    logic [30:0] ang;
    logic rv;
    logic signed [31:0] w[3];
  } rot_t;

  // model state
  logic [31:0] m_inv_inertia, m_max_vel, m_min_speed;
  logic [16:0] m_damping;
  longint m_w[3];

  rot_t rot_q[$];
  int errors = 0;
  int in_idle_pct = 0, out_stall_pct = 0;

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint fshr(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint ucap(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint unsigned sqrt_floor(longint unsigned n);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic longint unsigned speed_of(longint w[3]);
    longint unsigned s;
    s = 0;
    for (int i = 0; i < 3; i++) s += longint'(ucap(w[i])) * longint'(ucap(w[i]));
    return sqrt_floor(s);
  endfunction

  function automatic rot_t integrate_tick(tick_t t);
    rot_t r;
    longint v[3], n[3], acc[3], tq[3];
    longint unsigned spd, maxf, dt, ang, q;
    longint fac;
    acc = '{0, 0, 0};
    for (int i = 0; i < 3; i++) begin
      v[i] = clip32(longint'(t.tool[i]) - longint'(t.ctr[i]));
      n[i] = clip32(-longint'(t.frc[i]));
    end
    if (v[0] != 0 || v[1] != 0 || v[2] != 0) begin
      tq[0] = clip32(fshr(v[1] * n[2], FB) - fshr(v[2] * n[1], FB));
      tq[1] = clip32(fshr(v[2] * n[0], FB) - fshr(v[0] * n[2], FB));
      tq[2] = clip32(fshr(v[0] * n[1], FB) - fshr(v[1] * n[0], FB));
      for (int i = 0; i < 3; i++)
        acc[i] = clip32(fshr(tq[i] * longint'({32'd0, m_inv_inertia}), 16));
    end
    for (int i = 0; i < 3; i++)
      m_w[i] = clip32(m_w[i] + fshr(acc[i] * longint'({47'd0, t.ts}), 16));
    spd = speed_of(m_w);
    if ((spd << 16) > (longint'({32'd0, m_max_vel}) << FB)) begin
      maxf = {32'd0, m_max_vel};
      for (int i = 0; i < 3; i++) begin
        q = (longint'(ucap(m_w[i])) * maxf) / spd;
        m_w[i] = m_w[i] < 0 ? -longint'(q) : longint'(q);
      end
    end
    dt = ({47'd0, m_damping} * {47'd0, t.ts}) >> 16;
    fac = dt >= 64'd65536 ? 0 : longint'(64'd65536 - dt);
    for (int i = 0; i < 3; i++) m_w[i] = fshr(m_w[i] * fac, 16);
    if (t.sw) m_w = '{0, 0, 0};
    spd = speed_of(m_w);
    if ((spd << 16) > (longint'({48'd0, m_min_speed[15:0]}) << FB) && spd != 0) begin
      ang = ({47'd0, t.ts} * spd) >> 16;
      if (ang > 64'h7FFF_FFFF) ang = 64'h7FFF_FFFF;
      for (int i = 0; i < 3; i++) begin
        q = (longint'(ucap(m_w[i])) << 16) / spd;
        r.ax[i] = m_w[i] < 0 ? 18'(-longint'(q)) : 18'(q);
      end
      r.ang = ang[30:0];
      r.rv = 1'b1;
    end else begin
      r.ax = '{0, 0, 0};
      r.ang = '0;
      r.rv = 1'b0;
    end
    for (int i = 0; i < 3; i++) r.w[i] = m_w[i][31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      rot_t e;
      if (rot_q.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        e = rot_q.pop_front();
        if (axis_x !== e.ax[0]) report_mismatch("axis_x", axis_x, e.ax[0]);
        if (axis_y !== e.ax[1]) report_mismatch("axis_y", axis_y, e.ax[1]);
        if (axis_z !== e.ax[2]) report_mismatch("axis_z", axis_z, e.ax[2]);
        if (angle !== e.ang) report_mismatch("angle", angle, e.ang);
        if (rotate_valid !== e.rv) report_mismatch("rotate_valid", rotate_valid, e.rv);
        if (vel_x !== e.w[0]) report_mismatch("vel_x", vel_x, e.w[0]);
        if (vel_y !== e.w[1]) report_mismatch("vel_y", vel_y, e.w[1]);
        if (vel_z !== e.w[2]) report_mismatch("vel_z", vel_z, e.w[2]);
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_INV_INERTIA:   m_inv_inertia = val;
      CFG_VEL_CAP:       m_max_vel = val;
      CFG_DAMPING:       m_damping = val[16:0];
      CFG_MIN_ROT_SPEED: m_min_speed = {16'd0, val[15:0]};
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (rot_q.size() != 0) @(posedge clk);
    while (n < 400) begin
      @(posedge clk);
      n++;
    end
  endtask

  // known: expected result typed in; otherwise the predictor decides
  task automatic send_tick(tick_t t, logic known, rot_t want);
    rot_t p;
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < in_idle_pct) @(posedge clk);
    end
    tool_x <= t.tool[0]; tool_y <= t.tool[1]; tool_z <= t.tool[2];
    center_x <= t.ctr[0]; center_y <= t.ctr[1]; center_z <= t.ctr[2];
    force_x <= t.frc[0]; force_y <= t.frc[1]; force_z <= t.frc[2];
    time_step <= t.ts;
    user_switch <= t.sw;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = integrate_tick(t);
    rot_q.push_back(known ? want : p);
  endtask

  function automatic logic signed [31:0] rand_pos(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(131071)) - 65536;
      default: return $signed($urandom_range(16383)) - 8192;
    endcase
  endfunction

  function automatic tick_t rand_tick(int mode);
    tick_t t;
    for (int i = 0; i < 3; i++) begin
      t.tool[i] = rand_pos(mode);
      t.ctr[i] = ($urandom_range(7) == 0) ? t.tool[i] : rand_pos(mode);
      t.frc[i] = rand_pos(mode);
    end
    t.ts = ($urandom_range(9) == 0) ? 17'($urandom_range(65536))
                                     : 17'($urandom_range(3000));
    t.sw = ($urandom_range(19) == 0);
    return t;
  endfunction

  tick_t dir_tab[$];
  logic dir_known[$];
  rot_t dir_want[$];

  task automatic add_row(tick_t t, logic known, rot_t w);
    dir_tab.push_back(t);
    dir_known.push_back(known);
    dir_want.push_back(w);
  endtask

  initial begin
    tick_t t;
    rot_t z;
    logic signed [31:0] mn, mx;
    mn = 32'sh8000_0000;
    mx = 32'sh7FFF_FFFF;
    z.ax = '{0, 0, 0}; z.ang = '0; z.rv = 1'b0; z.w = '{0, 0, 0};
    m_inv_inertia = RST_INV_INERTIA;
    m_max_vel = RST_VEL_CAP;
    m_damping = RST_DAMPING;
    m_min_speed = {16'd0, RST_MIN_ROT_SPEED};
    m_w = '{0, 0, 0};

    // directed rows
    t.tool = '{0, 0, 0}; t.ctr = '{0, 0, 0}; t.frc = '{mx, mn, mx}; t.ts = 17'd65536; t.sw = 0;
    add_row(t, 1, z);                                  // zero lever arm
    t.tool = '{65536, 0, 0}; t.frc = '{0, 65536, 0}; t.ts = 17'd6554;
    add_row(t, 0, z);
    add_row(t, 0, z);
    t.tool = '{mx, mn, mx}; t.ctr = '{mn, mx, mn}; t.frc = '{mn, mx, mn}; t.ts = 17'd65536;
    add_row(t, 0, z);                                  // saturating arm, speed cap
    t.tool = '{mn, mn, mn}; t.ctr = '{mx, mx, mx}; t.frc = '{mx, mn, 0};
    add_row(t, 0, z);
    t.sw = 1; t.ts = 17'd1;
    add_row(t, 1, z);                                  // switch zeroes velocity
    t.sw = 0; t.ts = 17'd0;
    add_row(t, 1, z);                                  // no time elapsed, at rest
    t.tool = '{0, 131072, -65536}; t.ctr = '{1, 0, 0}; t.frc = '{-65536, 3, 65536};
    t.ts = 17'd1000;
    add_row(t, 0, z);
    t.ts = 17'd65535;
    add_row(t, 0, z);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) send_tick(dir_tab[i], dir_known[i], dir_want[i]);
    drain();

    // damping of one, huge inverse inertia, tiny cap
    cfg_write(CFG_DAMPING, 32'd65536);
    cfg_write(CFG_INV_INERTIA, 32'hFFFF_FFFF);
    cfg_write(CFG_VEL_CAP, 32'd1);
    cfg_write(CFG_MIN_ROT_SPEED, 32'd0);
    for (int i = 0; i < 12; i++) send_tick(rand_tick(i % 3), 0, z);
    drain();
    cfg_write(CFG_DAMPING, 32'd0);
    cfg_write(CFG_VEL_CAP, 32'hFFFF_FFFF);
    cfg_write(CFG_MIN_ROT_SPEED, 32'd65535);
    cfg_write(CFG_INV_INERTIA, 32'd0);
    for (int i = 0; i < 6; i++) send_tick(rand_tick(i % 3), 0, z);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin in_idle_pct = 0; out_stall_pct = 0; end
        1: begin in_idle_pct = 59; out_stall_pct = 0; end
        2: begin in_idle_pct = 0; out_stall_pct = 59; end
        default: begin in_idle_pct = 30; out_stall_pct = 30; end
      endcase
      cfg_write(CFG_INV_INERTIA, (ph == 4) ? 32'd0 : $urandom_range(400000));
      cfg_write(CFG_VEL_CAP, (ph == 6) ? 32'hFFFF_FFFF : $urandom_range(2000000));
      cfg_write(CFG_DAMPING, $urandom_range(65536));
      cfg_write(CFG_MIN_ROT_SPEED, (ph == 5) ? 32'd65535 : $urandom_range(200));
      for (int i = 0; i < 135; i++) begin
        send_tick(rand_tick($urandom_range(9) == 0 ? 0 : 1 + $urandom_range(1)), 0, z);
        if (i == 60 && ph == 1) begin
          in_valid <= 1'b0;
          while (rot_q.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
